### sv/frb_pkg.sv
package frb_pkg;

  // Default geometry of the fragment store
  localparam int unsigned MAX_FRAGS_DEF  = 8;
  localparam int unsigned FRAG_BYTES_DEF = 8;

  // Result status codes
  localparam logic [2:0] STAT_PENDING   = 3'd0;
  localparam logic [2:0] STAT_COMPLETE  = 3'd1;
  localparam logic [2:0] STAT_DUPLICATE = 3'd2;
  localparam logic [2:0] STAT_FORMAT    = 3'd3;
  localparam logic [2:0] STAT_BOUNDS    = 3'd4;

  // Register map
  localparam int unsigned APB_AW   = 2;
  localparam logic [1:0]  ADDR_CAP = 2'd0;
  localparam logic [7:0]  CAP_RESET = 8'd64;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 4;

endpackage

### sv/fragment_reassembly_bitmap_unit.sv
// Fragment reassembler: one fragment beat in, one or more result beats out.
// Flow: a decide step; a stored fragment then walks its payload bytes into the
// store, and its single result is loaded once the output is free (errors skip the store).
// A completing fragment instead sums the fragment lengths, checks the capacity,
// then reads out the message byte by byte, stepping past each fragment in turn.
// The block takes one fragment at a time. Reset: asynchronous, active low; assembly
// cleared, capacity set to 64.
module fragment_reassembly_bitmap_unit #(
  parameter int unsigned MAX_FRAGS  = frb_pkg::MAX_FRAGS_DEF,
  parameter int unsigned FRAG_BYTES = frb_pkg::FRAG_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Fragment in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: msg_id[15:0], src_node[23:16], frag_index[31:24], frag_count[39:32],
  //        payload_len[47:40], payload_bytes[111:48]
  input  logic [frb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: is_data_frame[0]
  input  logic [frb_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // Result out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: out_byte[7:0], total_length[14:8], zero[15]
  output logic [frb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: status[2:0], byte_valid[3]
  output logic [frb_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  // tlast: last_result
  output logic                             m_axis_tlast,
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [frb_pkg::APB_AW-1:0]       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned DEPTH = MAX_FRAGS * FRAG_BYTES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW    = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int unsigned CW    = $clog2(MAX_FRAGS + 1);
  localparam int unsigned LW    = $clog2(FRAG_BYTES + 1);
  localparam int unsigned TW    = $clog2(DEPTH + 1);
  localparam int unsigned MW    = AW + LW;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_PTR    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]  state_q;

  // Latched fragment
  logic        dat_q;
  logic [15:0] id_q;
  logic [7:0]  src_q;
  logic [7:0]  idx_q;
  logic [7:0]  cnt_q;
  logic [7:0]  len_q;
  logic [63:0] pay_q;

  // Assembly state
  logic                 assembling_q;
  logic [15:0]          cur_id_q;
  logic [7:0]           cur_src_q;
  logic [CW-1:0]        exp_cnt_q;
  logic [MAX_FRAGS-1:0] rcv_q;
  logic [LW-1:0]        lens_q [MAX_FRAGS];
  logic [7:0]           cap_q;

  // Sequencer working registers
  logic          full_q;
  logic [2:0]    stat_q;
  logic [FW-1:0] fptr_q;
  logic [LW-1:0] bptr_q;
  logic [TW-1:0] total_q;
  logic [TW-1:0] n_q;

  // Output register
  logic          m_valid_q;
  logic [2:0]    m_stat_q;
  logic [7:0]    m_byte_q;
  logic          m_bval_q;
  logic          m_last_q;
  logic [6:0]    m_total_q;

  logic s_acc;
  logic out_free;
  logic cfg_we;

  // Checks on the latched fragment
  logic                 bad;
  logic                 fresh;
  logic                 mismatch;
  logic                 dup;
  logic [FW-1:0]        idx_f;
  logic [MAX_FRAGS-1:0] rcv_base;
  logic [MAX_FRAGS-1:0] rcv_new;
  logic [MAX_FRAGS-1:0] full_mask;

  // Shared address unit and memory port
  logic [FW-1:0] sel_f;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_re;
  logic [7:0]    mem_rdata;
  logic [LW-1:0] cur_len;
  logic          load_single;
  logic          load_byte;
  logic          byte_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign cfg_we = psel && penable && pwrite && pready && (paddr == frb_pkg::ADDR_CAP);
  assign pready = 1'b1;
  assign prdata = (paddr == frb_pkg::ADDR_CAP) ? {24'd0, cap_q} : 32'd0;

  assign bad = (cnt_q == 8'd0) || (cnt_q > 8'(MAX_FRAGS)) || (idx_q >= cnt_q) ||
               (len_q > 8'(FRAG_BYTES));
  assign fresh    = !assembling_q || (cur_id_q != id_q) || (cur_src_q != src_q);
  assign mismatch = !fresh && (8'(exp_cnt_q) != cnt_q);
  assign idx_f    = idx_q[FW-1:0];
  assign rcv_base = fresh ? '0 : rcv_q;
  assign dup      = rcv_base[idx_f];
  assign rcv_new  = rcv_base | (MAX_FRAGS'(1) << idx_f);

  always_comb begin
    for (int i = 0; i < MAX_FRAGS; i++) begin
      full_mask[i] = (8'(i) < cnt_q);
    end
  end

  // One address unit serves both the store walk and the readout walk
  assign sel_f    = (state_q == S_WRITE) ? idx_f : fptr_q;
  assign mem_addr = AW'(MW'(sel_f) * MW'(FRAG_BYTES) + MW'(bptr_q));
  assign cur_len  = lens_q[fptr_q];
  assign mem_we   = (state_q == S_WRITE) && (bptr_q < LW'(len_q));
  assign mem_re   = (state_q == S_PTR) && (bptr_q < cur_len);

  assign load_single = (state_q == S_EMIT) && out_free;
  assign load_byte   = (state_q == S_OUT) && out_free;
  assign byte_last   = (n_q + TW'(1)) == total_q;

  frb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (pay_q[7:0]),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // Sequencer and assembly state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      assembling_q <= 1'b0;
      cur_id_q     <= '0;
      cur_src_q    <= '0;
      exp_cnt_q    <= '0;
      rcv_q        <= '0;
      cap_q        <= frb_pkg::CAP_RESET;
      full_q       <= 1'b0;
      stat_q       <= frb_pkg::STAT_PENDING;
      fptr_q       <= '0;
      bptr_q       <= '0;
      total_q      <= '0;
      n_q          <= '0;
    end else begin
      if (cfg_we) begin
        cap_q <= pwdata[7:0];
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!dat_q) begin
            stat_q  <= frb_pkg::STAT_FORMAT;
            state_q <= S_EMIT;
          end else if (bad) begin
            stat_q  <= frb_pkg::STAT_BOUNDS;
            state_q <= S_EMIT;
          end else if (mismatch) begin
            // Same message, different count: drop the assembly
            assembling_q <= 1'b0;
            cur_id_q     <= '0;
            cur_src_q    <= '0;
            exp_cnt_q    <= '0;
            rcv_q        <= '0;
            stat_q       <= frb_pkg::STAT_FORMAT;
            state_q      <= S_EMIT;
          end else begin
            // A fresh message starts from an empty mask, so it never sees a duplicate
            if (fresh) begin
              assembling_q <= 1'b1;
              cur_id_q     <= id_q;
              cur_src_q    <= src_q;
              exp_cnt_q    <= CW'(cnt_q);
            end
            if (dup) begin
              stat_q  <= frb_pkg::STAT_DUPLICATE;
              state_q <= S_EMIT;
            end else begin
              rcv_q   <= rcv_new;
              full_q  <= (rcv_new == full_mask);
              bptr_q  <= '0;
              state_q <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (bptr_q < LW'(len_q)) begin
            bptr_q <= bptr_q + LW'(1);
          end else if (full_q) begin
            fptr_q  <= '0;
            total_q <= '0;
            state_q <= S_SUM;
          end else begin
            stat_q  <= frb_pkg::STAT_PENDING;
            state_q <= S_EMIT;
          end
        end
        S_SUM: begin
          // Accumulate one fragment length per cycle
          total_q <= total_q + TW'(lens_q[fptr_q]);
          if ((CW+1)'(fptr_q) + (CW+1)'(1) == (CW+1)'(exp_cnt_q)) begin
            state_q <= S_CHECK;
          end else begin
            fptr_q <= fptr_q + FW'(1);
          end
        end
        S_CHECK: begin
          assembling_q <= 1'b0;
          cur_id_q     <= '0;
          cur_src_q    <= '0;
          exp_cnt_q    <= '0;
          rcv_q        <= '0;
          if (9'(total_q) > 9'(cap_q)) begin
            stat_q  <= frb_pkg::STAT_BOUNDS;
            state_q <= S_EMIT;
          end else if (total_q == '0) begin
            stat_q  <= frb_pkg::STAT_COMPLETE;
            state_q <= S_EMIT;
          end else begin
            fptr_q  <= '0;
            bptr_q  <= '0;
            n_q     <= '0;
            state_q <= S_PTR;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_PTR: begin
          // Skip to the next fragment once this one is read out
          if (bptr_q < cur_len) begin
            state_q <= S_OUT;
          end else begin
            fptr_q <= fptr_q + FW'(1);
            bptr_q <= '0;
          end
        end
        S_OUT: begin
          if (out_free) begin
            n_q    <= n_q + TW'(1);
            bptr_q <= bptr_q + LW'(1);
            state_q <= byte_last ? S_IDLE : S_PTR;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Latched fragment fields and fragment lengths
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      dat_q <= s_axis_tuser[0];
      id_q  <= s_axis_tdata[15:0];
      src_q <= s_axis_tdata[23:16];
      idx_q <= s_axis_tdata[31:24];
      cnt_q <= s_axis_tdata[39:32];
      len_q <= s_axis_tdata[47:40];
      pay_q <= s_axis_tdata[111:48];
    end else if (mem_we) begin
      // Advance to the next payload byte
      pay_q <= pay_q >> 8;
    end
    if ((state_q == S_DECIDE) && dat_q && !bad && !mismatch && !dup) begin
      lens_q[idx_f] <= LW'(len_q);
    end
  end

  // Output register: a waiting result does not hold off the next fragment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_single || load_byte) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_single) begin
      m_stat_q  <= stat_q;
      m_byte_q  <= '0;
      m_bval_q  <= 1'b0;
      m_last_q  <= 1'b1;
      m_total_q <= '0;
    end else if (load_byte) begin
      m_stat_q  <= frb_pkg::STAT_COMPLETE;
      m_byte_q  <= mem_rdata;
      m_bval_q  <= 1'b1;
      m_last_q  <= byte_last;
      m_total_q <= 7'(total_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_total_q, m_byte_q};
  assign m_axis_tuser  = {m_bval_q, m_stat_q};
  assign m_axis_tlast  = m_last_q;

endmodule

### sv/frb_ram.sv
module frb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/frb_checker.sv
module frb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [frb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [frb_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input logic                             m_axis_tlast
);

  // Accepting a fragment makes the block busy, so ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("fragment accepted on consecutive cycles");

  // Anything but a completed message is a single, final beat without a byte
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:0] != frb_pkg::STAT_COMPLETE)
    |-> m_axis_tlast && !m_axis_tuser[3])
    else $error("non-complete result not a single last beat");

  // Without a message byte, data carries nothing
  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata == '0)
    else $error("data set on a beat without a byte");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind fragment_reassembly_bitmap_unit frb_checker u_frb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### bench/tb_fragment_reassembly_bitmap_unit.sv
module tb_fragment_reassembly_bitmap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case per fragment: the walk through the block plus 64 result beats under
  // receiver stalls. The cycle limit is several times the slowest honest run.
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_GAP   = 8;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS  = 38;
  localparam int unsigned NUM_PHASES   = 6;

  // One fragment beat, field by field
  typedef struct {
    logic        is_data;
    logic [15:0] msg_id;
    logic [7:0]  src_node;
    logic [7:0]  frag_index;
    logic [7:0]  frag_count;
    logic [7:0]  payload_len;
    logic [63:0] payload_bytes;
  } frag_t;

  // One result beat, field by field
  typedef struct {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_result;
    logic [6:0] total_length;
  } result_t;

  // Directed row: typed = 1 means the single result is spelled out in want
  typedef struct {
    frag_t      frag;
    logic       typed;
    logic [2:0] want;
  } row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // tdata: msg_id[15:0], src_node[23:16], frag_index[31:24], frag_count[39:32],
  //        payload_len[47:40], payload_bytes[111:48]
  logic [frb_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // tuser: is_data_frame[0]
  logic [frb_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // tdata: out_byte[7:0], total_length[14:8], zero[15]
  logic [frb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // tuser: status[2:0], byte_valid[3]
  logic [frb_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [frb_pkg::APB_AW-1:0]     paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  fragment_reassembly_bitmap_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Reassembly predictor: own copy of the capacity register and assembly state
  // ---------------------------------------------------------------------------
  logic [7:0]  cap_reg = frb_pkg::CAP_RESET;
  logic        asm_active = 1'b0;
  logic [15:0] asm_id = '0;
  logic [7:0]  asm_src = '0;
  logic [7:0]  asm_count = '0;
  logic [7:0]  asm_mask = '0;
  logic [7:0]  byte_store [frb_pkg::MAX_FRAGS_DEF*frb_pkg::FRAG_BYTES_DEF];
  logic [3:0]  len_store [frb_pkg::MAX_FRAGS_DEF];

  result_t step_results[$];     // results of the fragment being predicted
  result_t awaited_results[$];  // results still owed by the block, oldest first

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Travels with each fragment beat so the monitor knows whether a result is typed in
  logic        row_typed = 1'b0;
  logic [2:0]  row_want = frb_pkg::STAT_PENDING;

  logic [15:0] last_id = '0;
  logic [7:0]  last_src = '0;

  function automatic result_t lone_result(input logic [2:0] st);
    result_t r;
    r.status       = st;
    r.out_byte     = '0;
    r.byte_valid   = 1'b0;
    r.last_result  = 1'b1;
    r.total_length = '0;
    return r;
  endfunction

  function automatic void clear_assembly();
    asm_active = 1'b0;
    asm_id     = '0;
    asm_src    = '0;
    asm_count  = '0;
    asm_mask   = '0;
  endfunction

  // Work out every result one fragment causes and advance the assembly state
  function automatic void reassemble_fragment(input frag_t f);
    int unsigned sum;
    int unsigned emitted;
    int unsigned b;
    int unsigned k;
    logic [8:0]  full_mask;
    logic [7:0]  idx_bit;
    result_t     r;
    step_results.delete();
    // Anything but a data frame is a format error and leaves the assembly alone
    if (!f.is_data) begin
      step_results.push_back(lone_result(frb_pkg::STAT_FORMAT));
      return;
    end
    // Out-of-range count, index or length is rejected before touching state
    if (f.frag_count == 0 || f.frag_count > frb_pkg::MAX_FRAGS_DEF ||
        f.frag_index >= f.frag_count || f.payload_len > frb_pkg::FRAG_BYTES_DEF) begin
      step_results.push_back(lone_result(frb_pkg::STAT_BOUNDS));
      return;
    end
    // A new id or source throws away whatever was being assembled
    if (!asm_active || asm_id != f.msg_id || asm_src != f.src_node) begin
      clear_assembly();
      asm_active = 1'b1;
      asm_id     = f.msg_id;
      asm_src    = f.src_node;
      asm_count  = f.frag_count;
    end
    if (asm_count != f.frag_count) begin
      clear_assembly();
      step_results.push_back(lone_result(frb_pkg::STAT_FORMAT));
      return;
    end
    idx_bit = 8'd1 << f.frag_index;
    if ((asm_mask & idx_bit) != 8'd0) begin
      step_results.push_back(lone_result(frb_pkg::STAT_DUPLICATE));
      return;
    end
    for (b = 0; b < f.payload_len; b++)
      byte_store[f.frag_index*frb_pkg::FRAG_BYTES_DEF + b] = f.payload_bytes[8*b +: 8];
    len_store[f.frag_index] = f.payload_len[3:0];
    asm_mask = asm_mask | idx_bit;
    full_mask = (9'd1 << f.frag_count) - 9'd1;
    if (asm_mask != full_mask[7:0]) begin
      step_results.push_back(lone_result(frb_pkg::STAT_PENDING));
      return;
    end
    sum = 0;
    for (k = 0; k < f.frag_count; k++)
      sum += len_store[k];
    if (sum > cap_reg) begin
      clear_assembly();
      step_results.push_back(lone_result(frb_pkg::STAT_BOUNDS));
      return;
    end
    // All fragments empty: one complete beat carrying no byte
    if (sum == 0) begin
      clear_assembly();
      step_results.push_back(lone_result(frb_pkg::STAT_COMPLETE));
      return;
    end
    emitted = 0;
    for (k = 0; k < f.frag_count; k++) begin
      for (b = 0; b < len_store[k]; b++) begin
        emitted++;
        r.status       = frb_pkg::STAT_COMPLETE;
        r.out_byte     = byte_store[k*frb_pkg::FRAG_BYTES_DEF + b];
        r.byte_valid   = 1'b1;
        r.last_result  = (emitted == sum);
        r.total_length = sum[6:0];
        step_results.push_back(r);
      end
    end
    clear_assembly();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch, %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check result beats, predict on every accepted fragment beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    frag_t   seen;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited, status",
                          m_axis_tuser[2:0], 0);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser[2:0] !== want.status)
            report_mismatch("status", m_axis_tuser[2:0], want.status);
          if (m_axis_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
          if (m_axis_tuser[3] !== want.byte_valid)
            report_mismatch("byte_valid", m_axis_tuser[3], want.byte_valid);
          if (m_axis_tlast !== want.last_result)
            report_mismatch("last_result", m_axis_tlast, want.last_result);
          if (m_axis_tdata[14:8] !== want.total_length)
            report_mismatch("total_length", m_axis_tdata[14:8], want.total_length);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.is_data       = s_axis_tuser[0];
        seen.msg_id        = s_axis_tdata[15:0];
        seen.src_node      = s_axis_tdata[23:16];
        seen.frag_index    = s_axis_tdata[31:24];
        seen.frag_count    = s_axis_tdata[39:32];
        seen.payload_len   = s_axis_tdata[47:40];
        seen.payload_bytes = s_axis_tdata[111:48];
        reassemble_fragment(seen);
        // Typed rows replace the prediction but still advance the state above
        if (row_typed) begin
          step_results.delete();
          step_results.push_back(lone_result(row_want));
        end
        foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      end
    end
  end

  // Receiver: stall at random, drive at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one fragment beat, idling first at random, and hold until it is taken
  task automatic send_frag(input frag_t f, input logic typed, input logic [2:0] want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f.is_data;
    s_axis_tdata  <= {f.payload_bytes, f.payload_len, f.frag_count, f.frag_index,
                      f.src_node, f.msg_id};
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Drop valid and let every owed result drain before touching the register
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_GAP) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= frb_pkg::ADDR_CAP;
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_reg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_capacity();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= frb_pkg::ADDR_CAP;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'd0, cap_reg})
      report_mismatch("capacity read-back", prdata, {24'd0, cap_reg});
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A well-formed message in shuffled order, with the odd fault slipped in
  task automatic send_message();
    frag_t       f;
    frag_t       g;
    int unsigned order [frb_pkg::MAX_FRAGS_DEF];
    int unsigned cnt;
    int unsigned j;
    int unsigned k;
    int unsigned tmp;
    int unsigned pick;
    f.is_data = 1'b1;
    // Reuse the previous id and source now and then, so restarts hit a live assembly
    if ($urandom_range(0, 3) == 0) begin
      f.msg_id   = last_id;
      f.src_node = last_src;
    end else begin
      f.msg_id   = 16'($urandom);
      f.src_node = 8'($urandom);
    end
    last_id  = f.msg_id;
    last_src = f.src_node;
    cnt = $urandom_range(1, frb_pkg::MAX_FRAGS_DEF);
    f.frag_count = 8'(cnt);
    for (k = 0; k < cnt; k++) order[k] = k;
    for (k = cnt - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < cnt; k++) begin
      f.frag_index    = 8'(order[k]);
      f.payload_len   = 8'($urandom_range(0, frb_pkg::FRAG_BYTES_DEF));
      f.payload_bytes = {$urandom, $urandom};
      send_frag(f, 1'b0, frb_pkg::STAT_PENDING);
      g    = f;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // resend the same index with fresh payload
        g.payload_bytes = {$urandom, $urandom};
        send_frag(g, 1'b0, frb_pkg::STAT_PENDING);
      end else if (pick < 7) begin
        // same fields but not a data frame
        g.is_data = 1'b0;
        send_frag(g, 1'b0, frb_pkg::STAT_PENDING);
      end else if (pick < 9) begin
        // same message, different claimed count
        g.frag_count = 8'((cnt % frb_pkg::MAX_FRAGS_DEF) + 1);
        g.frag_index = 8'd0;
        send_frag(g, 1'b0, frb_pkg::STAT_PENDING);
      end else if (pick < 11) begin
        // oversize payload length on the live message
        g.payload_len = 8'($urandom_range(frb_pkg::FRAG_BYTES_DEF + 1, 255));
        send_frag(g, 1'b0, frb_pkg::STAT_PENDING);
      end else if (pick < 14) begin
        // abandon the message half way
        return;
      end
    end
  endtask

  // Noise: anything the fields allow, half of it near the range edges
  task automatic send_stray();
    frag_t f;
    f.msg_id        = 16'($urandom);
    f.src_node      = 8'($urandom);
    f.payload_bytes = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) begin
      f.is_data     = 1'($urandom_range(0, 1));
      f.frag_index  = 8'($urandom_range(0, 255));
      f.frag_count  = 8'($urandom_range(0, 255));
      f.payload_len = 8'($urandom_range(0, 255));
    end else begin
      f.is_data     = 1'b1;
      f.frag_index  = 8'($urandom_range(0, frb_pkg::MAX_FRAGS_DEF));
      f.frag_count  = 8'($urandom_range(0, frb_pkg::MAX_FRAGS_DEF + 1));
      f.payload_len = 8'($urandom_range(0, frb_pkg::FRAG_BYTES_DEF + 1));
    end
    send_frag(f, 1'b0, frb_pkg::STAT_PENDING);
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 99) < 75) send_message();
      else send_stray();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  row_t directed_rows[$];

  function automatic void add_row(input logic typed, input logic [2:0] want,
                                  input logic is_data, input logic [15:0] id,
                                  input logic [7:0] src, input logic [7:0] idx,
                                  input logic [7:0] cnt, input logic [7:0] len,
                                  input logic [63:0] payload);
    row_t row;
    row.typed              = typed;
    row.want               = want;
    row.frag.is_data       = is_data;
    row.frag.msg_id        = id;
    row.frag.src_node      = src;
    row.frag.frag_index    = idx;
    row.frag.frag_count    = cnt;
    row.frag.payload_len   = len;
    row.frag.payload_bytes = payload;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    int unsigned k;
    //      typed want                     data  id        src    idx   cnt   len   payload
    // non-data frame with id, source and payload at their top values
    add_row(1'b1, frb_pkg::STAT_FORMAT,    1'b0, 16'hFFFF, 8'hFF, 8'd0, 8'd1, 8'd8, '1);
    // zero count, count above the maximum, index not below count, length too long, all at top
    add_row(1'b1, frb_pkg::STAT_BOUNDS,    1'b1, 16'h0001, 8'h01, 8'd0, 8'd0, 8'd1, 64'h11);
    add_row(1'b1, frb_pkg::STAT_BOUNDS,    1'b1, 16'h0001, 8'h01, 8'd0, 8'd9, 8'd1, 64'h22);
    add_row(1'b1, frb_pkg::STAT_BOUNDS,    1'b1, 16'h0001, 8'h01, 8'd3, 8'd3, 8'd1, 64'h33);
    add_row(1'b1, frb_pkg::STAT_BOUNDS,    1'b1, 16'h0001, 8'h01, 8'd0, 8'd2, 8'd9, 64'h44);
    add_row(1'b1, frb_pkg::STAT_BOUNDS,    1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1);
    // single-fragment message, eight bytes of all ones
    add_row(1'b0, frb_pkg::STAT_COMPLETE,  1'b1, 16'hFFFF, 8'hFF, 8'd0, 8'd1, 8'd8, '1);
    // empty complete message: one beat, no byte
    add_row(1'b1, frb_pkg::STAT_COMPLETE,  1'b1, 16'h0001, 8'h00, 8'd0, 8'd1, 8'd0, 64'h5A);
    // three fragments out of order, with a duplicate index in the middle
    add_row(1'b1, frb_pkg::STAT_PENDING,   1'b1, 16'h0005, 8'h01, 8'd2, 8'd3, 8'd3,
            64'h0000_0000_00C3_C2C1);
    add_row(1'b1, frb_pkg::STAT_DUPLICATE, 1'b1, 16'h0005, 8'h01, 8'd2, 8'd3, 8'd3,
            64'hDEAD_BEEF);
    add_row(1'b1, frb_pkg::STAT_PENDING,   1'b1, 16'h0005, 8'h01, 8'd0, 8'd3, 8'd8,
            64'hA7A6_A5A4_A3A2_A1A0);
    add_row(1'b0, frb_pkg::STAT_COMPLETE,  1'b1, 16'h0005, 8'h01, 8'd1, 8'd3, 8'd5,
            64'hFFFF_FFB4_B3B2_B1B0);
    // count mismatch clears the assembly
    add_row(1'b1, frb_pkg::STAT_PENDING,   1'b1, 16'h0006, 8'h01, 8'd0, 8'd2, 8'd4,
            64'h1234_5678);
    add_row(1'b1, frb_pkg::STAT_FORMAT,    1'b1, 16'h0006, 8'h01, 8'd1, 8'd3, 8'd4,
            64'h9ABC_DEF0);
    // restart on a new id, then again on a new source with the same id
    add_row(1'b1, frb_pkg::STAT_PENDING,   1'b1, 16'h0007, 8'h01, 8'd0, 8'd2, 8'd2, 64'h0102);
    add_row(1'b1, frb_pkg::STAT_PENDING,   1'b1, 16'h0007, 8'h02, 8'd1, 8'd2, 8'd1, 64'h0003);
    add_row(1'b0, frb_pkg::STAT_COMPLETE,  1'b1, 16'h0007, 8'h02, 8'd0, 8'd2, 8'd2, 64'h0504);
    // largest message: eight full fragments, 64 bytes, exactly at the reset capacity
    for (k = 0; k < frb_pkg::MAX_FRAGS_DEF; k++)
      add_row(k != frb_pkg::MAX_FRAGS_DEF - 1, frb_pkg::STAT_PENDING, 1'b1, 16'h0000, 8'h00,
              8'(frb_pkg::MAX_FRAGS_DEF - 1 - k), 8'(frb_pkg::MAX_FRAGS_DEF),
              8'(frb_pkg::FRAG_BYTES_DEF),
              {8{8'(8'h10 * (frb_pkg::MAX_FRAGS_DEF - 1 - k) + 8'h0F)}} ^
              64'h0706_0504_0302_0100);
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [7:0] caps [NUM_PHASES];
    int unsigned p;
    caps[0] = 8'd255;
    caps[1] = 8'd0;
    caps[2] = 8'd63;
    caps[3] = 8'd12;
    caps[4] = 8'($urandom_range(0, 255));
    caps[5] = frb_pkg::CAP_RESET;
    build_directed();
    send_idle_pct = 16;
    recv_idle_pct = 62;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset value of the capacity register
    check_capacity();

    foreach (directed_rows[i])
      send_frag(directed_rows[i].frag, directed_rows[i].typed, directed_rows[i].want);

    // Random phases: receiver-heavy idling, then sender-heavy, then none
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_capacity(caps[p]);
      check_capacity();
      case (p / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random(PHASE_ITEMS);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", awaited_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
